FILE: rtl/phc_pkg.sv
// Shared types, constants and helper functions for the pump hysteresis controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package phc_pkg;

	// Sizing of the datapath.
	localparam int READING_BITS = 10;
	localparam int COUNT_BITS   = 8;

	// Configuration register file layout.
	localparam int CFG_NUM    = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int PERIOD_W   = 8;
	localparam int TH_W       = 10;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_PERIOD = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_LIMIT  = cfg_idx_t'(1);
	localparam cfg_idx_t CFG_DRY    = cfg_idx_t'(2);
	localparam cfg_idx_t CFG_WET    = cfg_idx_t'(3);
	localparam cfg_idx_t CFG_UPPER  = cfg_idx_t'(4);
	localparam cfg_idx_t CFG_LOWER  = cfg_idx_t'(5);

	// Register values after reset.
	localparam logic [PERIOD_W-1:0] RST_PERIOD = PERIOD_W'(8);
	localparam logic [PERIOD_W-1:0] RST_LIMIT  = PERIOD_W'(8);
	localparam logic [TH_W-1:0]     RST_DRY    = TH_W'(412);
	localparam logic [TH_W-1:0]     RST_WET    = TH_W'(385);
	localparam logic [TH_W-1:0]     RST_UPPER  = TH_W'(550);
	localparam logic [TH_W-1:0]     RST_LOWER  = TH_W'(250);

	// Widths used when counters meet settings and readings meet thresholds.
	localparam int CNT_CMP_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;
	localparam int RD_CMP_W  = (READING_BITS > TH_W) ? READING_BITS : TH_W;

	typedef logic [READING_BITS-1:0] reading_t;
	typedef logic [COUNT_BITS-1:0]   count_t;
	typedef logic [RD_CMP_W-1:0]     rd_cmp_t;

	localparam count_t COUNT_MAX = '1;

	// Stop reason codes.
	typedef logic [1:0] stop_t;
	localparam stop_t STOP_NONE  = 2'd0;
	localparam stop_t STOP_WET   = 2'd1;
	localparam stop_t STOP_LIMIT = 2'd2;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] limit;
		logic [TH_W-1:0]     dry;
		logic [TH_W-1:0]     wet;
		logic [TH_W-1:0]     upper;
		logic [TH_W-1:0]     lower;
	} cfg_t;

	typedef struct packed {
		logic  pump_drive;
		logic  measured;
		logic  out_of_range;
		stop_t stop_reason;
	} result_t;

	// Counter increment that sticks at the largest count.
	function automatic count_t sat_inc(input count_t v);
		count_t r;
		if (v == COUNT_MAX) begin
			r = COUNT_MAX;
		end else begin
			r = v + count_t'(1);
		end
		return r;
	endfunction

	// A setting wider than the counter is limited to the largest count.
	function automatic count_t clamp_count(input logic [PERIOD_W-1:0] v);
		logic [CNT_CMP_W-1:0] ve;
		count_t r;
		ve = CNT_CMP_W'(v);
		if (ve > CNT_CMP_W'(COUNT_MAX)) begin
			r = COUNT_MAX;
		end else begin
			r = count_t'(ve);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/phc_cfg.sv
// Configuration register file of the pump hysteresis controller.
// Depends on phc_pkg for the register layout and reset values.
`default_nettype none

module phc_cfg (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire phc_pkg::cfg_idx_t       cfg_addr,
	input  wire logic [phc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output phc_pkg::cfg_t                cfg
);
	import phc_pkg::*;

	cfg_t cfg_q;

	// Write one register per enabled cycle; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period <= RST_PERIOD;
			cfg_q.limit  <= RST_LIMIT;
			cfg_q.dry    <= RST_DRY;
			cfg_q.wet    <= RST_WET;
			cfg_q.upper  <= RST_UPPER;
			cfg_q.lower  <= RST_LOWER;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_PERIOD: cfg_q.period <= cfg_wdata[PERIOD_W-1:0];
				CFG_LIMIT:  cfg_q.limit  <= cfg_wdata[PERIOD_W-1:0];
				CFG_DRY:    cfg_q.dry    <= cfg_wdata[TH_W-1:0];
				CFG_WET:    cfg_q.wet    <= cfg_wdata[TH_W-1:0];
				CFG_UPPER:  cfg_q.upper  <= cfg_wdata[TH_W-1:0];
				CFG_LOWER:  cfg_q.lower  <= cfg_wdata[TH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/phc_step.sv
// Per-tick decision logic and controller state (idle count, run count, pump flag).
// Depends on phc_pkg for types, stop codes and the counter helpers.
`default_nettype none

module phc_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire phc_pkg::reading_t reading,
	input  wire phc_pkg::cfg_t     cfg,
	output phc_pkg::result_t       res
);
	import phc_pkg::*;

	count_t idle_count_q;
	count_t run_count_q;
	logic   pumping_q;

	count_t  idle_count_d;
	count_t  run_count_d;
	logic    pumping_d;
	count_t  idle_inc;
	count_t  run_inc;
	count_t  period;
	count_t  limit;
	rd_cmp_t rd;
	logic    is_wet;
	logic    timeout;
	logic    oor;
	logic    is_dry;

	assign period  = clamp_count(cfg.period);
	assign limit   = clamp_count(cfg.limit);
	assign idle_inc = sat_inc(idle_count_q);
	assign run_inc  = sat_inc(run_count_q);

	// Reading and thresholds are compared at a common width.
	assign rd      = RD_CMP_W'(reading);
	assign is_wet  = rd < RD_CMP_W'(cfg.wet);
	assign is_dry  = rd > RD_CMP_W'(cfg.dry);
	assign oor     = (rd > RD_CMP_W'(cfg.upper)) || (rd < RD_CMP_W'(cfg.lower));
	assign timeout = run_inc >= limit;

	// Next state and the result of this tick.
	always_comb begin
		idle_count_d     = idle_count_q;
		run_count_d      = run_count_q;
		pumping_d        = pumping_q;
		res.measured     = 1'b0;
		res.out_of_range = 1'b0;
		res.stop_reason  = STOP_NONE;
		if (pumping_q) begin
			run_count_d  = run_inc;
			res.measured = 1'b1;
			if (is_wet || timeout) begin
				res.stop_reason = is_wet ? STOP_WET : STOP_LIMIT;
				pumping_d       = 1'b0;
				idle_count_d    = '0;
			end
		end else begin
			idle_count_d = idle_inc;
			if (idle_inc >= period) begin
				idle_count_d = '0;
				res.measured = 1'b1;
				if (oor) begin
					res.out_of_range = 1'b1;
				end else if (is_dry) begin
					pumping_d   = 1'b1;
					run_count_d = '0;
				end
			end
		end
		res.pump_drive = pumping_d;
	end

	// State advances once per accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_count_q <= '0;
			run_count_q  <= '0;
			pumping_q    <= 1'b0;
		end else if (acc) begin
			idle_count_q <= idle_count_d;
			run_count_q  <= run_count_d;
			pumping_q    <= pumping_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/phc_obuf.sv
// Result register with a skid stage that takes one more beat while a result waits.
// Depends on phc_pkg for the result type.
`default_nettype none

module phc_obuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             acc,
	input  wire phc_pkg::result_t res,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output phc_pkg::result_t      out_res
);
	import phc_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_res_q;
	result_t skid_res_q;
	logic    out_pop;

	assign out_pop = out_valid_q && !out_stall;

	// Control: the skid holds a beat only while the result register is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (out_valid_q && !out_pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload moves without reset.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop) begin
				out_res_q <= skid_res_q;
			end
		end else if (acc) begin
			if (out_valid_q && !out_pop) begin
				skid_res_q <= res;
			end else begin
				out_res_q <= res;
			end
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

`default_nettype wire

FILE: rtl/pump_hysteresis_controller_top.sv
// Pump hysteresis controller: on/off pump control with a run-time limit.
// Input channel: one beat per watchdog tick with the averaged moisture reading
// (in_valid/in_stall). Output channel: one result beat per input beat with the
// pump level, a measured flag, an out-of-range flag and the stop reason
// (out_valid/out_stall). A beat is taken when valid is high and stall is low.
// Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata), register
// index as listed: period, limit, dry, wet, upper, lower; other indexes ignored.
// A result is registered in the result register, or in the skid stage while that
// register is blocked. One beat per cycle is taken while in_stall is low; the
// decision is made by compares and a counter increment ahead of the result register.
// Reset clears the counters and the pump flag, loads the register defaults and
// empties the output stages. When the receiver stalls, one more input beat is
// taken into a skid stage, after which in_stall rises until the result drains.
// Depends on phc_pkg, phc_cfg, phc_step and phc_obuf.
`default_nettype none

module pump_hysteresis_controller_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [phc_pkg::READING_BITS-1:0] reading,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                pump_drive,
	output logic                                measured,
	output logic                                out_of_range,
	output logic [1:0]                          stop_reason,
	input  wire logic                           cfg_we,
	input  wire logic [phc_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [phc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import phc_pkg::*;

	cfg_t    cfg;
	result_t res;
	result_t out_res;
	logic    acc;

	assign acc = in_valid && !in_stall;

	phc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	phc_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.reading (reading),
		.cfg     (cfg),
		.res     (res)
	);

	phc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.res       (res),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign pump_drive   = out_res.pump_drive;
	assign measured     = out_res.measured;
	assign out_of_range = out_res.out_of_range;
	assign stop_reason  = out_res.stop_reason;

`ifndef SYNTHESIS
	// The skid stage fills only behind a waiting result.
	a_skid_behind_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid stage occupied while result register is empty");

	// A stop is always a measured tick that leaves the pump off.
	a_stop_pump_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stop_reason != STOP_NONE) |-> (measured && !pump_drive))
		else $error("stop reported without measurement or with pump on");

	// An out-of-range reading never runs the pump or reports a stop.
	a_oor_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |->
		(measured && !pump_drive && stop_reason == STOP_NONE))
		else $error("out-of-range beat with pump activity");

	// An unstalled result leaves the register unless another beat replaces it.
	a_result_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !in_stall && !acc) |=> !out_valid)
		else $error("result register did not drain");
`endif

endmodule

`default_nettype wire
